FILE: rtl/core/arpm_pkg.sv
// shared types, constants and the log2 fraction table of the level meter
package arpm_pkg;

  localparam int SUM_W = 42;
  localparam int LOG_W = 22;
  localparam int DIFF_W = 24;
  localparam int MAG_W = 17;
  localparam int PROD_W = 42;
  localparam int DB_W = 18;

  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
  localparam logic [DB_W-1:0] DB_FLOOR = 18'd25600;
  localparam logic signed [15:0] LEVEL_FLOOR = -16'sd25600;
  localparam logic [18:0] RMS_SCALE = 19'd197283;
  localparam logic [18:0] PEAK_SCALE = 19'd394566;
  localparam logic signed [DIFF_W-1:0] RMS_OFFSET = 24'sd1966080;
  localparam logic signed [DIFF_W-1:0] PEAK_OFFSET = 24'sd983040;
  localparam logic [PROD_W-1:0] ROUND_HALF = 42'd8388608;

  typedef struct packed {
    logic signed [15:0] sample;
    logic frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] channel;
    logic signed [15:0] rms_db;
    logic signed [15:0] peak_db;
    logic last;
  } out_item_t;

  typedef enum logic [2:0] {
    LS_SETS = 3'b001,
    LS_SUM  = 3'b010,
    LS_PEAK = 3'b100
  } log_src_t;

  typedef struct packed {
    logic emit_sel;
    logic log_start;
    log_src_t log_src;
    logic lsets_en;
    logic is_peak;
    logic diff_en;
    logic mul_en;
    logic rnd_en;
    logic rms_floor;
    logic peak_floor;
    logic chan_first;
    logic chan_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic log_done;
    logic sum_zero;
    logic peak_zero;
    logic last_ch;
  } sts_t;

  function automatic logic [16:0] log_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0: v = 17'd0;
      5'd1: v = 17'd5732;
      5'd2: v = 17'd11136;
      5'd3: v = 17'd16248;
      5'd4: v = 17'd21098;
      5'd5: v = 17'd25711;
      5'd6: v = 17'd30110;
      5'd7: v = 17'd34312;
      5'd8: v = 17'd38336;
      5'd9: v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/audio_rms_peak_meter.sv
// audio rms and peak level meter, top level
// in channel: in_data carries one signed 16-bit sample per item, channels
// interleaved in a cycle of channel_count; frame_end marks the last sample.
// out channel: after a frame, one item per active channel, channel 0 first,
// with rms and peak levels in 1/256 dbfs, floor -100 db; last marks the end.
// cfg channel: cfg_data writes channel_count (always ready); the user writes it
// only while idle, which the block itself does not enforce. samples are taken
// one per cycle while no frame is being reported: the square and add of a
// sample complete in the cycle after it is taken. a frame-end item starts
// reporting: the set count log, then for each channel the rms and peak levels,
// each from the iterative log2 unit (byte then bit normalize steps, one table
// multiply) and the shared level multiplier; a silent channel skips both logs;
// input stalls meanwhile.
// a stalled result holds in_data intake off and the payload steady until taken;
// the stores are cleared when the last channel's item is taken.
// reset (synchronous) clears all stores and sets channel_count to 2.
module audio_rms_peak_meter import arpm_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_FRAME_SETS = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  logic      in_valid,
  output logic      in_stall,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_stall,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [3:0] cfg_data
);

  logic [3:0] channel_count;
  logic in_accept;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) channel_count <= 4'd2;
    else if (cfg_valid && cfg_ready) channel_count <= cfg_data;
  end

  arpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .frame_end (in_data.frame_end),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  arpm_datapath #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_FRAME_SETS (MAX_FRAME_SETS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_accept     (in_accept),
    .sample        (in_data.sample),
    .channel_count (channel_count),
    .cmd           (cmd),
    .sts           (sts),
    .out_data      (out_data)
  );

endmodule

FILE: rtl/core/arpm_log2.sv
// iterative log2 unit in q16: normalize, table lookup, interpolate
module arpm_log2 import arpm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] x,
  output logic             done,
  output logic [LOG_W-1:0] result
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_NORM = 4'b0010,
    L_MUL  = 4'b0100,
    L_ADD  = 4'b1000
  } lstate_t;

  lstate_t state;
  logic [SUM_W-1:0] norm;
  logic [5:0] expo;
  logic [16:0] frac_lo;
  logic [24:0] prod;
  logic [16:0] lo;
  logic [16:0] hi;
  logic [12:0] delta;
  logic big_step;

  always_comb begin
    lo = log_tab({1'b0, norm[40:37]});
    hi = log_tab(5'({1'b0, norm[40:37]} + 5'd1));
    delta = 13'(hi - lo);
    big_step = (norm[41:34] == 8'd0) && (expo >= 6'd8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == L_ADD);
      unique case (state)
        L_IDLE: if (start) state <= L_NORM;
        L_NORM: if (norm[41] || expo == 6'd0) state <= L_MUL;
        L_MUL: state <= L_ADD;
        L_ADD: state <= L_IDLE;
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == L_IDLE && start) begin
      norm <= x;
      expo <= 6'd41;
    end else if (state == L_NORM && !(norm[41] || expo == 6'd0)) begin
      if (big_step) begin
        norm <= norm << 8;
        expo <= expo - 6'd8;
      end else begin
        norm <= norm << 1;
        expo <= expo - 6'd1;
      end
    end
    if (state == L_MUL) begin
      prod <= delta * norm[36:25];
      frac_lo <= lo;
    end
    if (state == L_ADD) begin
      result <= {expo, 16'd0} + LOG_W'(frac_lo) + LOG_W'(prod[24:12]);
    end
  end

endmodule

FILE: rtl/core/arpm_datapath.sv
// channel stores, accumulation and dbfs level arithmetic
module arpm_datapath import arpm_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_FRAME_SETS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  logic signed [15:0] sample,
  input  logic [3:0]        channel_count,
  input  cmd_t              cmd,
  output sts_t              sts,
  output out_item_t         out_data
);

  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNTW = $clog2(MAX_FRAME_SETS + 1);
  localparam int SETW = $clog2(MAX_FRAME_SETS + 2);

  logic [3:0] cnt_act;
  logic [CHW-1:0] channel_index;
  logic [CHW-1:0] ch_cur;
  logic last_of_set;
  logic [CNTW-1:0] set_count;
  logic partial;
  logic signed [MAG_W-1:0] s_ext;
  logic [MAG_W-1:0] mag;

  logic st_valid;
  logic [CHW-1:0] st_ch;
  logic [MAG_W-1:0] st_mag;

  logic [SUM_W-1:0] sum_sq [MAX_CHANNELS];
  logic [MAG_W-1:0] peak_mag [MAX_CHANNELS];
  logic [CHW-1:0] rd_ch;
  logic [SUM_W-1:0] rd_sum;
  logic [MAG_W-1:0] rd_peak;
  logic [33:0] sq;
  logic [SUM_W:0] sum_add;
  logic [SUM_W-1:0] sum_next;

  logic [CHW-1:0] emit_ch;
  logic [SETW-1:0] sets;
  logic [SUM_W-1:0] log_x;
  logic log_done;
  logic [LOG_W-1:0] log_res;
  logic [LOG_W-1:0] lsets;
  logic signed [DIFF_W-1:0] ldiff;
  logic signed [DIFF_W-1:0] diff_next;
  logic nonneg;
  logic [PROD_W-1:0] prod;
  logic [22:0] mag_l;
  logic [PROD_W-1:0] prod_round;
  logic [DB_W-1:0] dbr;
  logic signed [15:0] lvl;
  logic signed [15:0] rms_db;
  logic signed [15:0] peak_db;

  always_comb begin
    if (channel_count == 4'd0) cnt_act = 4'd1;
    else if (channel_count > 4'(MAX_CHANNELS)) cnt_act = 4'(MAX_CHANNELS);
    else cnt_act = channel_count;
    ch_cur = (4'(channel_index) >= cnt_act) ? '0 : channel_index;
    last_of_set = (4'(ch_cur) == cnt_act - 4'd1);
    s_ext = {sample[15], sample};
    mag = s_ext[MAG_W-1] ? MAG_W'(-s_ext) : MAG_W'(s_ext);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      channel_index <= '0;
      set_count <= '0;
    end else if (in_accept) begin
      channel_index <= last_of_set ? '0 : CHW'(ch_cur + 1'b1);
      if (last_of_set && set_count < CNTW'(MAX_FRAME_SETS)) set_count <= set_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) st_valid <= 1'b0;
    else st_valid <= in_accept;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      st_ch <= ch_cur;
      st_mag <= mag;
      partial <= !last_of_set;
    end
  end

  always_comb begin
    rd_ch = cmd.emit_sel ? emit_ch : st_ch;
    rd_sum = sum_sq[rd_ch];
    rd_peak = peak_mag[rd_ch];
    sq = st_mag * st_mag;
    sum_add = {1'b0, rd_sum} + (SUM_W + 1)'(sq);
    sum_next = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sum_sq[i] <= '0;
        peak_mag[i] <= '0;
      end
    end else if (st_valid) begin
      sum_sq[st_ch] <= sum_next;
      if (st_mag > rd_peak) peak_mag[st_ch] <= st_mag;
    end
  end

  always_comb begin
    sets = SETW'(set_count) + SETW'(partial);
    case (cmd.log_src)
      LS_SETS: log_x = SUM_W'(sets);
      LS_SUM:  log_x = rd_sum;
      LS_PEAK: log_x = SUM_W'(rd_peak);
      default: log_x = '0;
    endcase
  end

  arpm_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  always_comb begin
    if (cmd.is_peak) diff_next = $signed({2'b00, log_res}) - PEAK_OFFSET;
    else diff_next = $signed({2'b00, log_res}) - $signed({2'b00, lsets}) - RMS_OFFSET;
    mag_l = 23'(-ldiff);
    prod_round = prod + ROUND_HALF;
    dbr = prod_round[PROD_W-1:24];
    if (nonneg) lvl = 16'sd0;
    else if (dbr > DB_FLOOR) lvl = LEVEL_FLOOR;
    else lvl = 16'sd0 - $signed({1'b0, dbr[14:0]});
  end

  always_ff @(posedge clk) begin
    if (cmd.lsets_en) lsets <= log_res;
    if (cmd.diff_en) ldiff <= diff_next;
    if (cmd.mul_en) begin
      nonneg <= !ldiff[DIFF_W-1];
      prod <= mag_l * (cmd.is_peak ? PEAK_SCALE : RMS_SCALE);
    end
    if (cmd.rms_floor) rms_db <= LEVEL_FLOOR;
    else if (cmd.rnd_en && !cmd.is_peak) rms_db <= lvl;
    if (cmd.peak_floor) peak_db <= LEVEL_FLOOR;
    else if (cmd.rnd_en && cmd.is_peak) peak_db <= lvl;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.chan_first) emit_ch <= '0;
    else if (cmd.chan_next) emit_ch <= CHW'(emit_ch + 1'b1);
  end

  always_comb begin
    sts.log_done = log_done;
    sts.sum_zero = (rd_sum == '0);
    sts.peak_zero = (rd_peak == '0);
    sts.last_ch = (4'(emit_ch) == cnt_act - 4'd1);
    out_data.channel = 3'(emit_ch);
    out_data.rms_db = rms_db;
    out_data.peak_db = peak_db;
    out_data.last = sts.last_ch;
  end

endmodule

FILE: rtl/core/arpm_ctrl.sv
// controller state machine: sample intake and per-channel level emission
module arpm_ctrl import arpm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_accept,
  input  logic frame_end,
  input  logic out_stall,
  input  sts_t sts,
  output logic in_stall,
  output logic out_valid,
  output cmd_t cmd
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DRAIN  = 15'b000000000000010,
    S_SETS   = 15'b000000000000100,
    S_SETS_W = 15'b000000000001000,
    S_SUM    = 15'b000000000010000,
    S_SUM_W  = 15'b000000000100000,
    S_RDIFF  = 15'b000000001000000,
    S_RMUL   = 15'b000000010000000,
    S_RRND   = 15'b000000100000000,
    S_PEAK   = 15'b000001000000000,
    S_PEAK_W = 15'b000010000000000,
    S_PDIFF  = 15'b000100000000000,
    S_PMUL   = 15'b001000000000000,
    S_PRND   = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.log_src = LS_SETS;
    cmd.emit_sel = !(state == S_IDLE || state == S_DRAIN);
    in_stall = (state != S_IDLE);
    out_valid = (state == S_OUT);
    unique case (state)
      S_IDLE: if (in_accept && frame_end) state_next = S_DRAIN;
      S_DRAIN: state_next = S_SETS;
      S_SETS: begin
        cmd.log_start = 1'b1;
        state_next = S_SETS_W;
      end
      S_SETS_W: if (sts.log_done) begin
        cmd.lsets_en = 1'b1;
        cmd.chan_first = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.log_src = LS_SUM;
        if (sts.sum_zero) begin
          cmd.rms_floor = 1'b1;
          state_next = S_PEAK;
        end else begin
          cmd.log_start = 1'b1;
          state_next = S_SUM_W;
        end
      end
      S_SUM_W: if (sts.log_done) state_next = S_RDIFF;
      S_RDIFF: begin
        cmd.diff_en = 1'b1;
        state_next = S_RMUL;
      end
      S_RMUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_RRND;
      end
      S_RRND: begin
        cmd.rnd_en = 1'b1;
        state_next = S_PEAK;
      end
      S_PEAK: begin
        cmd.log_src = LS_PEAK;
        if (sts.peak_zero) begin
          cmd.peak_floor = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.log_start = 1'b1;
          state_next = S_PEAK_W;
        end
      end
      S_PEAK_W: if (sts.log_done) state_next = S_PDIFF;
      S_PDIFF: begin
        cmd.is_peak = 1'b1;
        cmd.diff_en = 1'b1;
        state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.is_peak = 1'b1;
        cmd.mul_en = 1'b1;
        state_next = S_PRND;
      end
      S_PRND: begin
        cmd.is_peak = 1'b1;
        cmd.rnd_en = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (!out_stall) begin
        if (sts.last_ch) begin
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.chan_next = 1'b1;
          state_next = S_SUM;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

FILE: tb/arpm_checker.sv
// checker of the level meter: predicts levels from accepted samples and compares results
module arpm_checker import arpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  logic      in_valid,
  input  logic      in_stall,
  input  out_item_t out_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [3:0] cfg_data,
  output int        fail_count,
  output int        pending
);

  localparam logic [41:0] SUM_MAX = {42{1'b1}};
  localparam int SETS_MAX = 4096;

  logic [3:0] chan_cfg;
  logic [2:0] next_chan;
  logic [41:0] sq_sum [8];
  logic [16:0] peak_mag [8];
  int sets_done;
  out_item_t level_queue [$];

  function automatic logic [63:0] log2_fix(input logic [63:0] x);
    int e;
    logic [15:0] f;
    logic [16:0] lo, hi;
    logic [63:0] r;
    e = 0;
    for (int b = 0; b < 64; b++) if (x[b]) e = b;
    if (e >= 16) f = 16'(x >> (e - 16));
    else f = 16'(x << (16 - e));
    lo = log_tab({1'b0, f[15:12]});
    hi = log_tab(5'({1'b0, f[15:12]} + 5'd1));
    r = 64'(hi - lo) * 64'(f[11:0]);
    return (64'(e) << 16) + 64'(lo) + (r >> 12);
  endfunction

  function automatic logic signed [15:0] level_db(input longint l, input longint scale);
    longint db;
    if (l >= 0) return 16'sd0;
    db = ((-l) * scale + (64'sd1 <<< 23)) >>> 24;
    if (db > 25600) return -16'sd25600;
    return 16'(-db);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    fail_count++;
  endtask

  task automatic take_sample(input in_item_t it);
    int cnt, ch, partial;
    logic [16:0] mag;
    logic [42:0] acc;
    longint sets, l;
    out_item_t r;
    cnt = (chan_cfg == 0) ? 1 : (chan_cfg > 8) ? 8 : chan_cfg;
    ch = next_chan;
    if (ch >= cnt) ch = 0;
    mag = it.sample[15] ? 17'(17'h10000 - {1'b0, it.sample}) : {1'b0, it.sample};
    acc = {1'b0, sq_sum[ch]} + 43'(mag * mag);
    sq_sum[ch] = acc[42] ? SUM_MAX : acc[41:0];
    if (mag > peak_mag[ch]) peak_mag[ch] = mag;
    if (ch == cnt - 1) begin
      if (sets_done < SETS_MAX) sets_done++;
      next_chan = 0;
      partial = 0;
    end else begin
      next_chan = 3'(ch + 1);
      partial = 1;
    end
    if (!it.frame_end) return;
    sets = sets_done + partial;
    for (int k = 0; k < cnt; k++) begin
      r.channel = 3'(k);
      r.rms_db = -16'sd25600;
      r.peak_db = -16'sd25600;
      if (sq_sum[k] != 0) begin
        l = longint'(log2_fix(64'(sq_sum[k]))) - longint'(log2_fix(64'(sets))) - (64'sd30 <<< 16);
        r.rms_db = level_db(l, 197283);
      end
      if (peak_mag[k] != 0) begin
        l = longint'(log2_fix(64'(peak_mag[k]))) - (64'sd15 <<< 16);
        r.peak_db = level_db(l, 394566);
      end
      r.last = (k == cnt - 1);
      level_queue.push_back(r);
    end
    for (int k = 0; k < 8; k++) begin
      sq_sum[k] = 0;
      peak_mag[k] = 0;
    end
    next_chan = 0;
    sets_done = 0;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_item_t w;
    if (rst) begin
      chan_cfg = 4'd2;
      next_chan = 0;
      sets_done = 0;
      for (int k = 0; k < 8; k++) begin
        sq_sum[k] = 0;
        peak_mag[k] = 0;
      end
      level_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (level_queue.size() == 0) begin
          report_mismatch("unexpected item, channel", out_data.channel, -1);
        end else begin
          w = level_queue.pop_front();
          if (out_data.channel !== w.channel) report_mismatch("channel", out_data.channel, w.channel);
          if (out_data.rms_db !== w.rms_db) report_mismatch("rms_db", out_data.rms_db, w.rms_db);
          if (out_data.peak_db !== w.peak_db)
            report_mismatch("peak_db", out_data.peak_db, w.peak_db);
          if (out_data.last !== w.last) report_mismatch("last", out_data.last, w.last);
        end
      end
      if (in_valid && !in_stall) take_sample(in_data);
      if (cfg_valid && cfg_ready) chan_cfg = cfg_data;
    end
    pending = level_queue.size();
  end

endmodule

FILE: tb/tb_audio_rms_peak_meter.sv
// testbench top of the level meter: stimulus, configuration phases and verdict
module tb_audio_rms_peak_meter import arpm_pkg::*;;

  logic clk, rst;
  in_item_t in_data;
  logic in_valid, in_stall;
  out_item_t out_data;
  logic out_valid, out_stall;
  logic cfg_valid, cfg_ready;
  logic [3:0] cfg_data;
  int fail_count, pending;
  bit calm;

  audio_rms_peak_meter i_dut (
    .clk, .rst, .in_data, .in_valid, .in_stall, .out_data, .out_valid, .out_stall,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  arpm_checker i_checker (
    .clk, .rst, .in_data, .in_valid, .in_stall, .out_data, .out_valid, .out_stall,
    .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall = 0;
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] s, input logic fe);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_data.sample = s;
    in_data.frame_end = fe;
    in_valid = 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic set_channels(input logic [3:0] n);
    drain();
    cfg_data = n;
    cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int sent, len;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = 4'd2;
    calm = 0;
    repeat (8) @(negedge clk);
    rst = 0;
    // directed: default count, extremes, silence, partial set
    send_sample(16'sh8000, 0);
    send_sample(16'sh7fff, 0);
    send_sample(16'sh0001, 0);
    send_sample(16'shffff, 1);
    send_sample(16'sh0000, 0);
    send_sample(16'sh0000, 1);
    send_sample(16'sh1234, 1);
    set_channels(4'd1);
    send_sample(16'sh8000, 1);
    send_sample(16'sh0000, 1);
    set_channels(4'd8);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7fff, i == 7);
    send_sample(16'sh5555, 0);
    send_sample(16'shaaaa, 1);
    set_channels(4'd0);
    send_sample(16'sh0100, 0);
    send_sample(16'sh0100, 1);
    set_channels(4'd15);
    for (int i = 0; i < 9; i++) send_sample(16'sh8000, i == 8);
    // count changed mid-frame
    set_channels(4'd4);
    send_sample(16'sh0700, 0);
    send_sample(16'sh0700, 0);
    send_sample(16'sh0700, 0);
    set_channels(4'd2);
    send_sample(16'sh0070, 1);
    // one longer frame of full scale
    set_channels(4'd1);
    for (int i = 0; i < 40; i++) send_sample(16'sh8000, i == 39);
    sent = 0;
    while (sent < 195) begin
      set_channels(4'($urandom_range(1, 8)));
      len = $urandom_range(1, 24);
      for (int i = 0; i < len && sent < 195; i++) begin
        if (sent > 160) calm = 1;
        send_sample(pick_sample(), (i == len - 1) || ($urandom_range(0, 40) == 0));
        sent++;
      end
    end
    send_sample(16'sh0001, 1);
    calm = 1;
    fork
      drain();
      begin
        repeat (200000) @(negedge clk);
      end
    join_any
    if (pending == 0 && fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
